// ===== sv/ffs_pkg.sv =====
// ffs_pkg: shared types and constants of the flipbook frame sequencer
// used by ffs_ctrl, ffs_datapath and flipbook_frame_sequencer_unit
// no dependencies
package ffs_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    localparam int CLIP_LEN_W  = 7;
    localparam int LOOP_MODE_W = 2;
    localparam int SLOT_W      = 6;
    localparam int MS_W        = 16;
    localparam int ATLAS_W     = 16;
    localparam int ACC_W       = 17;
    localparam int FRAME_OUT_W = 6;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_CLIP_LEN  = 1'b0;
    localparam logic REG_IDX_LOOP_MODE = 1'b1;

    localparam logic [LOOP_MODE_W-1:0] LOOP_WRAP   = 2'd0;
    localparam logic [LOOP_MODE_W-1:0] LOOP_REWIND = 2'd1;
    localparam logic [LOOP_MODE_W-1:0] LOOP_HOLD   = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_PLAY    = 2'd1,
        OP_TICK    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_STARTED = 2'd1,
        EV_STOPPED = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_ATLAS,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic walk_step;
        logic load_out;
    } ffs_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic tick_run;
        logic step_hit;
        logic out_free;
    } ffs_sts_t;

endpackage

// ===== sv/ffs_ctrl.sv =====
// ffs_ctrl: state machine that sequences one item through the datapath
// depends on ffs_pkg
module ffs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ffs_pkg::ffs_sts_t sts,
    output ffs_pkg::ffs_cmd_t cmd
);

    ffs_pkg::state_t state_reg;
    ffs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ffs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ffs_pkg::ST_EXEC;
                end
            end
            ffs_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.op == ffs_pkg::OP_TICK && sts.tick_run)
                begin
                    state_next = ffs_pkg::ST_WALK_RD;
                end
                else
                begin
                    state_next = ffs_pkg::ST_ATLAS;
                end
            end
            // duration of the current frame is read here
            ffs_pkg::ST_WALK_RD:
            begin
                state_next = ffs_pkg::ST_WALK_CMP;
            end
            ffs_pkg::ST_WALK_CMP:
            begin
                if (sts.step_hit)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = ffs_pkg::ST_WALK_RD;
                end
                else
                begin
                    state_next = ffs_pkg::ST_ATLAS;
                end
            end
            ffs_pkg::ST_ATLAS:
            begin
                state_next = ffs_pkg::ST_DONE;
            end
            ffs_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ffs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffs_pkg::ST_IDLE;
            end
        endcase
    end

    // a walk step only happens while comparing
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |=> state_reg == ffs_pkg::ST_WALK_RD)
        else $error("walk step did not return to the duration read");

    // an item is taken only when the controller is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ffs_pkg::ST_EXEC)
        else $error("accepted item was not executed");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending one");

endmodule

// ===== sv/ffs_datapath.sv =====
// ffs_datapath: frame tables, position, accumulator, playing flag and output register
// depends on ffs_pkg
module ffs_datapath
#(
    parameter int MAX_FRAMES = ffs_pkg::MAX_FRAMES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ffs_pkg::ffs_cmd_t                   cmd,
    output ffs_pkg::ffs_sts_t                   sts,
    input  ffs_pkg::op_t                        in_op,
    input  logic [ffs_pkg::SLOT_W-1:0]          in_slot,
    input  logic [ffs_pkg::MS_W-1:0]            in_duration,
    input  logic [ffs_pkg::ATLAS_W-1:0]         in_atlas,
    input  logic                                in_play,
    input  logic [ffs_pkg::MS_W-1:0]            in_elapsed,
    input  logic [ffs_pkg::CLIP_LEN_W-1:0]      clip_length,
    input  logic [ffs_pkg::LOOP_MODE_W-1:0]     loop_mode,
    input  logic                                clip_load,
    input  logic [ffs_pkg::CLIP_LEN_W-1:0]      clip_length_next,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [ffs_pkg::FRAME_OUT_W-1:0]     frame_now,
    output logic [ffs_pkg::ATLAS_W-1:0]         atlas_now,
    output logic                                playing_now,
    output ffs_pkg::event_t                     event_res
);

    localparam int POS_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [ffs_pkg::MS_W-1:0]    dur_mem [MAX_FRAMES];
    logic [ffs_pkg::ATLAS_W-1:0] atlas_mem [MAX_FRAMES];
    logic [ffs_pkg::MS_W-1:0]    dur_q;
    logic [ffs_pkg::ATLAS_W-1:0] atlas_q;

    ffs_pkg::op_t                op_reg;
    logic [ffs_pkg::SLOT_W-1:0]  slot_reg;
    logic [ffs_pkg::MS_W-1:0]    duration_reg;
    logic [ffs_pkg::ATLAS_W-1:0] atlas_reg;
    logic                        play_reg;
    logic [ffs_pkg::MS_W-1:0]    elapsed_reg;

    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic [ffs_pkg::ACC_W-1:0]   acc_reg;
    logic [ffs_pkg::ACC_W-1:0]   acc_next;
    logic                        playing_reg;
    logic                        playing_next;
    ffs_pkg::event_t             event_reg;
    ffs_pkg::event_t             event_next;

    logic                        out_valid_reg;
    logic [ffs_pkg::FRAME_OUT_W-1:0] frame_out_reg;
    logic [ffs_pkg::ATLAS_W-1:0] atlas_out_reg;
    logic                        playing_out_reg;
    ffs_pkg::event_t             event_out_reg;

    logic [CNT_W-1:0]            eff_len;
    logic                        has_clip;
    logic                        slot_ok;
    logic                        tbl_wr;
    logic [ffs_pkg::ACC_W-1:0]   dur_eff;
    logic [ffs_pkg::ACC_W-1:0]   acc_sub;
    logic [CNT_W-1:0]            pos_inc;

    always_comb
    begin
        if (32'(clip_length) > MAX_FRAMES)
        begin
            eff_len = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            eff_len = CNT_W'(clip_length);
        end
    end

    assign has_clip = (eff_len != '0);
    assign slot_ok  = (32'(slot_reg) < MAX_FRAMES);
    assign tbl_wr   = cmd.exec && (op_reg == ffs_pkg::OP_WRITE) && slot_ok;
    assign dur_eff  = (dur_q == '0) ? ffs_pkg::ACC_W'(1) : ffs_pkg::ACC_W'(dur_q);
    assign acc_sub  = acc_reg - dur_eff;
    assign pos_inc  = CNT_W'(pos_reg) + CNT_W'(1);

    // frame tables, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            dur_mem[POS_W'(slot_reg)]   <= duration_reg;
            atlas_mem[POS_W'(slot_reg)] <= atlas_reg;
        end
        dur_q   <= dur_mem[pos_reg];
        atlas_q <= atlas_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= in_op;
            slot_reg     <= in_slot;
            duration_reg <= in_duration;
            atlas_reg    <= in_atlas;
            play_reg     <= in_play;
            elapsed_reg  <= in_elapsed;
        end
        if (cmd.load_out)
        begin
            frame_out_reg   <= ffs_pkg::FRAME_OUT_W'(pos_reg);
            atlas_out_reg   <= has_clip ? atlas_q : '0;
            playing_out_reg <= playing_reg;
            event_out_reg   <= event_reg;
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        playing_next = playing_reg;
        event_next   = event_reg;
        if (clip_load)
        begin
            pos_next = '0;
            acc_next = '0;
            if (clip_length_next == '0)
            begin
                playing_next = 1'b0;
            end
        end
        else if (cmd.capture)
        begin
            event_next = ffs_pkg::EV_NONE;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                ffs_pkg::OP_PLAY:
                begin
                    if (has_clip)
                    begin
                        if (!playing_reg && play_reg)
                        begin
                            event_next = ffs_pkg::EV_STARTED;
                        end
                        playing_next = play_reg;
                    end
                end
                ffs_pkg::OP_TICK:
                begin
                    if (playing_reg && has_clip)
                    begin
                        acc_next = acc_reg + ffs_pkg::ACC_W'(elapsed_reg);
                    end
                end
                ffs_pkg::OP_RESTART:
                begin
                    pos_next = '0;
                    acc_next = '0;
                    if (!has_clip)
                    begin
                        playing_next = 1'b0;
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
        else if (cmd.walk_step)
        begin
            if (pos_inc >= eff_len)
            begin
                case (loop_mode)
                    ffs_pkg::LOOP_WRAP:
                    begin
                        pos_next = '0;
                        acc_next = acc_sub;
                    end
                    ffs_pkg::LOOP_REWIND:
                    begin
                        pos_next     = '0;
                        acc_next     = '0;
                        playing_next = 1'b0;
                        event_next   = ffs_pkg::EV_STOPPED;
                    end
                    default:
                    begin
                        // hold the last frame, unused mode included
                        pos_next     = POS_W'(eff_len - CNT_W'(1));
                        acc_next     = '0;
                        playing_next = 1'b0;
                        event_next   = ffs_pkg::EV_STOPPED;
                    end
                endcase
            end
            else
            begin
                pos_next = POS_W'(pos_inc);
                acc_next = acc_sub;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            acc_reg       <= '0;
            playing_reg   <= 1'b0;
            event_reg     <= ffs_pkg::EV_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            playing_reg <= playing_next;
            event_reg   <= event_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.op       = op_reg;
        sts.tick_run = playing_reg && has_clip;
        sts.step_hit = playing_reg && (acc_reg >= dur_eff);
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign frame_now   = frame_out_reg;
    assign atlas_now   = atlas_out_reg;
    assign playing_now = playing_out_reg;
    assign event_res   = event_out_reg;

    // the position never leaves the loaded clip
    assert property (@(posedge clk) disable iff (!rst_n)
        has_clip |-> (CNT_W'(pos_reg) < eff_len))
        else $error("frame position beyond clip length");

    // between items the accumulator stays within the 16-bit duration range
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !acc_reg[ffs_pkg::ACC_W-1])
        else $error("accumulator left above duration range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && event_reg == ffs_pkg::EV_STARTED) |-> playing_reg)
        else $error("started event while not playing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && event_reg == ffs_pkg::EV_STOPPED) |-> !playing_reg)
        else $error("stopped event while still playing");

endmodule

// ===== sv/flipbook_frame_sequencer_unit.sv =====
// flipbook_frame_sequencer_unit: top level, register port and stream packing
// depends on ffs_pkg, ffs_ctrl, ffs_datapath
//
// channel   dir  handshake          contents
// s_        in   s_tvalid/s_tready  tuser op, tdata frame entry / play / elapsed ms
// m_        out  m_tvalid/m_tready  tdata frame, atlas index, playing, event
// apb       in   psel/penable       clip_length at 0x0, loop_mode at 0x4
//
// write, play and restart items pass the idle, exec, atlas and done states before the next accept
// running ticks add a duration table read and a compare per frame advanced, before atlas
// ticks while stopped or with no clip take the same states as the other items
// one item at a time; a finished result waits in the output register while the next is taken
// a result still waiting on m_tready holds the following one back until it is taken
// rst_n clears position, accumulator, playing flag, registers and control; tables need writes
module flipbook_frame_sequencer_unit
#(
    parameter int MAX_FRAMES = ffs_pkg::MAX_FRAMES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] entry_slot, [21:6] entry_duration, [37:22] entry_atlas,
    // [38] play, [54:39] elapsed_ms, [55] unused
    input  logic [55:0]                     s_tdata,
    // [1:0] op
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] frame_now, [21:6] atlas_now, [22] playing_now, [24:23] event_res,
    // [31:25] zero
    output logic [31:0]                     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ffs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ffs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [ffs_pkg::CLIP_LEN_W-1:0]  clip_length_reg;
    logic [ffs_pkg::LOOP_MODE_W-1:0] loop_mode_reg;
    logic                            cfg_wr;
    logic                            clip_load;

    ffs_pkg::ffs_cmd_t               cmd;
    ffs_pkg::ffs_sts_t               sts;

    logic [ffs_pkg::FRAME_OUT_W-1:0] frame_now;
    logic [ffs_pkg::ATLAS_W-1:0]     atlas_now;
    logic                            playing_now;
    ffs_pkg::event_t                 event_res;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign clip_load = cfg_wr && (paddr[2] == ffs_pkg::REG_IDX_CLIP_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_length_reg <= '0;
            loop_mode_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ffs_pkg::REG_IDX_CLIP_LEN:
                begin
                    clip_length_reg <= pwdata[ffs_pkg::CLIP_LEN_W-1:0];
                end
                ffs_pkg::REG_IDX_LOOP_MODE:
                begin
                    loop_mode_reg <= pwdata[ffs_pkg::LOOP_MODE_W-1:0];
                end
                default:
                begin
                    loop_mode_reg <= loop_mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ffs_pkg::REG_IDX_CLIP_LEN:
            begin
                prdata = ffs_pkg::APB_DATA_W'(clip_length_reg);
            end
            ffs_pkg::REG_IDX_LOOP_MODE:
            begin
                prdata = ffs_pkg::APB_DATA_W'(loop_mode_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    ffs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffs_datapath
    #(
        .MAX_FRAMES (MAX_FRAMES)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_op            (ffs_pkg::op_t'(s_tuser)),
        .in_slot          (s_tdata[5:0]),
        .in_duration      (s_tdata[21:6]),
        .in_atlas         (s_tdata[37:22]),
        .in_play          (s_tdata[38]),
        .in_elapsed       (s_tdata[54:39]),
        .clip_length      (clip_length_reg),
        .loop_mode        (loop_mode_reg),
        .clip_load        (clip_load),
        .clip_length_next (pwdata[ffs_pkg::CLIP_LEN_W-1:0]),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .frame_now        (frame_now),
        .atlas_now        (atlas_now),
        .playing_now      (playing_now),
        .event_res        (event_res)
    );

    assign m_tdata = {7'd0, event_res, playing_now, atlas_now, frame_now};

endmodule
